// File: rtl/ifhg_pkg.sv
// Shared types and constants of the IPv4 fragment header generator.
package ifhg_pkg;

  localparam int MAX_FRAGS = 64;
  localparam int CNT_W     = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_SRC_IP        = 2'd0;
  localparam logic [1:0] REG_FRAG_UNITS    = 2'd1;
  localparam logic [1:0] REG_NO_FRAG_LIMIT = 2'd2;

  localparam logic [31:0] SRC_IP_RST        = 32'd0;
  localparam logic [9:0]  FRAG_UNITS_RST    = 10'd185;
  localparam logic [15:0] NO_FRAG_LIMIT_RST = 16'd576;

  localparam logic [9:0]  FRAG_UNITS_MIN = 10'd128;
  localparam logic [9:0]  FRAG_UNITS_MAX = 10'd1000;
  localparam logic [12:0] IP_HDR_BYTES   = 13'd20;
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [7:0]  IP_TTL         = 8'hFF;

  typedef struct packed {
    logic [15:0] message_length;
    logic [12:0] sent_units;
    logic [31:0] dst_ip;
    logic [15:0] packet_id;
    logic [7:0]  protocol;
  } msg_item_t;

  typedef struct packed {
    logic [15:0] frag_byte_offset;
    logic [12:0] payload_len;
    logic [12:0] total_length;
    logic [15:0] flags_offset;
    logic [15:0] header_checksum;
    logic        last;
  } frag_item_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [9:0]  frag_units;
    logic [15:0] no_frag_limit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic nothing_left;
    logic load_ok;
    logic frag_done;
  } sts_t;

endpackage

// File: rtl/ifhg_if.sv
// Valid/ready channel interfaces for message descriptors and fragment headers.
interface ifhg_msg_if import ifhg_pkg::*; ();
  logic      valid;
  logic      ready;
  msg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ifhg_frag_if import ifhg_pkg::*; ();
  logic       valid;
  logic       ready;
  frag_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ifhg_regs.sv
// APB configuration registers of the fragment header generator.
module ifhg_regs import ifhg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.src_ip        <= SRC_IP_RST;
      cfg.frag_units    <= FRAG_UNITS_RST;
      cfg.no_frag_limit <= NO_FRAG_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_IP:        cfg.src_ip        <= pwdata;
        REG_FRAG_UNITS:    cfg.frag_units    <= pwdata[9:0];
        REG_NO_FRAG_LIMIT: cfg.no_frag_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_IP:        prdata = cfg.src_ip;
      REG_FRAG_UNITS:    prdata = {22'd0, cfg.frag_units};
      REG_NO_FRAG_LIMIT: prdata = {16'd0, cfg.no_frag_limit};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: rtl/ifhg_ctrl.sv
// Controller state machine: capture, prepare, then step out fragments.
module ifhg_ctrl import ifhg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic msg_valid,
  output logic msg_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PREP = 3'b010,
    S_RUN  = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    msg_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = sts.nothing_left ? S_IDLE : S_RUN;
      end
      S_RUN: begin
        // advance one fragment whenever the output register can take it
        if (sts.load_ok) begin
          cmd.step = 1'b1;
          if (sts.frag_done) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/ifhg_dp.sv
// Datapath: remainder tracking, header fields, checksum and output register.
module ifhg_dp import ifhg_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  msg_item_t msg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic      frag_ready,
  output logic      frag_valid,
  output frag_item_t frag_data
);

  msg_item_t        item;
  logic [15:0]      base_sum;
  logic [12:0]      fbytes;
  logic [15:0]      left;
  logic [15:0]      off;
  logic [CNT_W-1:0] cnt;

  logic [15:0] sent_bytes;
  logic [18:0] base_raw;
  logic [16:0] base_f1;
  logic [15:0] base_f2;
  logic [9:0]  units;

  logic        is_last;
  logic [12:0] plen;
  logic [12:0] tot;
  logic [12:0] ounits;
  logic        df;
  logic [15:0] fo;
  logic [17:0] sum_raw;
  logic [16:0] sum_f1;
  logic [15:0] sum_f2;

  assign sent_bytes = {item.sent_units, 3'b000};

  // message-wide part of the header sum, folded to 16 bits
  always_comb begin
    base_raw = 19'(IP_VER_IHL_TOS) + 19'({IP_TTL, item.protocol}) + 19'(item.packet_id)
             + 19'(cfg.src_ip[31:16]) + 19'(cfg.src_ip[15:0])
             + 19'(item.dst_ip[31:16]) + 19'(item.dst_ip[15:0]);
    base_f1  = 17'(base_raw[15:0]) + 17'(base_raw[18:16]);
    base_f2  = base_f1[15:0] + 16'(base_f1[16]);
  end

  always_comb begin
    if (cfg.frag_units < FRAG_UNITS_MIN) begin
      units = FRAG_UNITS_MIN;
    end else if (cfg.frag_units > FRAG_UNITS_MAX) begin
      units = FRAG_UNITS_MAX;
    end else begin
      units = cfg.frag_units;
    end
  end

  // per-fragment fields
  always_comb begin
    is_last = left <= {3'b000, fbytes};
    plen    = is_last ? left[12:0] : fbytes;
    tot     = plen + IP_HDR_BYTES;
    ounits  = off[15:3];
    df      = ({3'b000, tot} <= cfg.no_frag_limit) && (ounits == 13'd0);
    fo      = {1'b0, df, ~is_last, ounits};
    sum_raw = 18'(base_sum) + 18'(tot) + 18'(fo);
    sum_f1  = 17'(sum_raw[15:0]) + 17'(sum_raw[17:16]);
    sum_f2  = sum_f1[15:0] + 16'(sum_f1[16]);
  end

  assign sts.nothing_left = sent_bytes >= item.message_length;
  assign sts.load_ok      = !frag_valid || frag_ready;
  assign sts.frag_done    = is_last || (cnt == CNT_W'(MAX_FRAGS - 1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= msg_data;
    end
    if (cmd.prep) begin
      base_sum <= base_f2;
      fbytes   <= {units, 3'b000};
      left     <= item.message_length - sent_bytes;
      off      <= sent_bytes;
      cnt      <= '0;
    end else if (cmd.step) begin
      left <= left - 16'(plen);
      off  <= off + 16'(plen);
      cnt  <= cnt + CNT_W'(1);
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      frag_valid <= 1'b0;
    end else if (cmd.step) begin
      frag_valid <= 1'b1;
    end else if (frag_ready) begin
      frag_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      frag_data.frag_byte_offset <= off;
      frag_data.payload_len      <= plen;
      frag_data.total_length     <= tot;
      frag_data.flags_offset     <= fo;
      frag_data.header_checksum  <= ~sum_f2;
      frag_data.last             <= is_last;
    end
  end

endmodule

// File: rtl/ipv4_fragment_header_gen.sv
// Top level of the IPv4 fragment header generator.
// Usage:
//   msg  - sink channel of message descriptors (length, units already sent,
//          destination, id, protocol); one item is taken only while the
//          block is idle.
//   frag - source channel of fragment headers, one item per fragment, with
//          offset, payload length, total length, flags/offset, checksum, last.
//   APB  - registers src_ip (0x0), frag_units (0x4), no_frag_limit (0x8);
//          write only while no message is in progress.
// The descriptor is captured, the prepare state loads the header sum and
// remainder, and the run state steps fragments into the output register.
// Fragments follow one per cycle while frag is ready; a message with nothing
// left gives no fragment. The rate is set by the single fragment stepper
// of the datapath, which advances one fragment per cycle into one output
// register. A stalled receiver holds that register and the stepper waits;
// the next descriptor is taken as soon as the last fragment is in the output
// register. Reset restores the register defaults and drops any pending item.
module ipv4_fragment_header_gen import ifhg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ifhg_msg_if.sink          msg,
  ifhg_frag_if.source       frag,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ifhg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ifhg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ifhg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .msg_data   (msg.data),
    .cmd        (cmd),
    .sts        (sts),
    .frag_ready (frag.ready),
    .frag_valid (frag.valid),
    .frag_data  (frag.data)
  );

endmodule
